// ===== rtl/utlc_pkg.sv =====
`default_nettype none

package utlc_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_EAST   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_OFFSET = 1'b1;

  localparam logic        ZONE_EAST_RST   = 1'b1;
  localparam logic [15:0] ZONE_OFFSET_RST = 16'd28800;

  localparam logic [16:0] DAY_SECONDS    = 17'd86400;
  localparam logic [16:0] HOUR_SECONDS   = 17'd3600;
  localparam logic [11:0] MINUTE_SECONDS = 12'd60;

  // ceil(2^30 / 3600) and ceil(2^18 / 60): exact over the ranges used
  localparam logic [18:0] HOUR_RECIP   = 19'd298262;
  localparam logic [12:0] MINUTE_RECIP = 13'd4370;

  localparam logic [6:0] YEAR_MAX   = 7'd99;
  localparam logic [3:0] MONTH_JAN  = 4'd1;
  localparam logic [3:0] MONTH_FEB  = 4'd2;
  localparam logic [3:0] MONTH_MAR  = 4'd3;
  localparam logic [3:0] MONTH_DEC  = 4'd12;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;

  typedef struct packed {
    logic [6:0] utc_year;
    logic [3:0] utc_month;
    logic [4:0] utc_day;
    logic [4:0] utc_hour;
    logic [5:0] utc_minute;
    logic [5:0] utc_second;
  } utc_in_t;

  typedef struct packed {
    logic [7:0]  local_year_bcd;
    logic [4:0]  local_month_bcd;
    logic [5:0]  local_day_bcd;
    logic [5:0]  local_hour_bcd;
    logic [6:0]  local_minute_bcd;
    logic [6:0]  local_second_bcd;
    logic [2:0]  local_weekday;
    logic [16:0] local_day_seconds;
  } local_out_t;

  function automatic logic [4:0] days_in(input logic [6:0] year, input logic [3:0] month);
    logic [4:0] d;
    unique case (month)
      MONTH_FEB:            d = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default:              d = 5'd31;
    endcase
    return d;
  endfunction

  // (13 * (m + 1) / 5) mod 7, with January and February as months 13 and 14
  function automatic logic [2:0] zeller_term(input logic [3:0] month);
    logic [2:0] t;
    unique case (month)
      4'd1:    t = 3'd1;
      4'd2:    t = 3'd4;
      4'd3:    t = 3'd3;
      4'd4:    t = 3'd6;
      4'd5:    t = 3'd1;
      4'd6:    t = 3'd4;
      4'd7:    t = 3'd6;
      4'd8:    t = 3'd2;
      4'd9:    t = 3'd5;
      4'd10:   t = 3'd0;
      4'd11:   t = 3'd3;
      4'd12:   t = 3'd5;
      default: t = 3'd0;
    endcase
    return t;
  endfunction

  // exact for v up to 203
  function automatic logic [2:0] mod7(input logic [7:0] v);
    logic [15:0] p;
    logic [7:0]  q;
    logic [7:0]  r;
    p = {8'b0, v} * 16'd147;
    q = {2'b0, p[15:10]};
    r = v - 8'(q * 8'd7);
    return r[2:0];
  endfunction

  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [17:0] p;
    logic [3:0]  tens;
    logic [6:0]  ones;
    p    = {11'b0, v} * 18'd205;
    tens = p[14:11];
    ones = v - 7'({3'b0, tens} * 7'd10);
    return {tens, ones[3:0]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/utc_to_local_time_converter.sv =====
// Throughput: one item per cycle while out_ready does not stall the output;
// seven register stages split the offset add, the date roll, the two
// reciprocal multiplies and the BCD packing.
// Reset (rst_n low, synchronous): pipeline emptied, zone_east = 1,
// zone_offset_seconds = 28800.
`default_nettype none

module utc_to_local_time_converter (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_we,
  input  wire  [utlc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [utlc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  utlc_pkg::utc_in_t              in_data,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output utlc_pkg::local_out_t                 out_data
);
  import utlc_pkg::*;

  typedef struct packed {
    logic [6:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  mlen;
    logic [16:0] secs;
  } stg_b_t;

  typedef struct packed {
    logic [6:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [16:0] loc_secs;
  } stg_c_t;

  typedef struct packed {
    logic [6:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [16:0] loc_secs;
    logic [4:0]  hour;
    logic [7:0]  wsum;
  } stg_d_t;

  typedef struct packed {
    logic [6:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [16:0] loc_secs;
    logic [4:0]  hour;
    logic [11:0] rem;
    logic [2:0]  weekday;
  } stg_e_t;

  typedef struct packed {
    logic [6:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [16:0] loc_secs;
    logic [4:0]  hour;
    logic [11:0] rem;
    logic [5:0]  minute;
    logic [2:0]  weekday;
  } stg_f_t;

  logic        zone_east_r;
  logic [15:0] zone_offset_r;

  logic v_a_r, v_b_r, v_c_r, v_d_r, v_e_r, v_f_r, out_valid_r;
  logic en_a, en_b, en_c, en_d, en_e, en_f, en_o;

  utc_in_t    a_r;
  stg_b_t     b_r, b_nxt;
  stg_c_t     c_r, c_nxt;
  stg_d_t     d_r, d_nxt;
  stg_e_t     e_r, e_nxt;
  stg_f_t     f_r, f_nxt;
  local_out_t out_r, out_nxt;

  assign en_o = !out_valid_r || out_ready;
  assign en_f = !v_f_r || en_o;
  assign en_e = !v_e_r || en_f;
  assign en_d = !v_d_r || en_e;
  assign en_c = !v_c_r || en_d;
  assign en_b = !v_b_r || en_c;
  assign en_a = !v_a_r || en_b;

  assign in_ready  = en_a;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_east_r   <= ZONE_EAST_RST;
      zone_offset_r <= ZONE_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ZONE_EAST:   zone_east_r   <= cfg_wdata[0];
        CFG_ZONE_OFFSET: zone_offset_r <= cfg_wdata[15:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r       <= 1'b0;
      v_b_r       <= 1'b0;
      v_c_r       <= 1'b0;
      v_d_r       <= 1'b0;
      v_e_r       <= 1'b0;
      v_f_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_a) v_a_r <= in_valid;
      if (en_b) v_b_r <= v_a_r;
      if (en_c) v_c_r <= v_b_r;
      if (en_d) v_d_r <= v_c_r;
      if (en_e) v_e_r <= v_d_r;
      if (en_f) v_f_r <= v_e_r;
      if (en_o) out_valid_r <= v_f_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) a_r   <= in_data;
    if (en_b) b_r   <= b_nxt;
    if (en_c) c_r   <= c_nxt;
    if (en_d) d_r   <= d_nxt;
    if (en_e) e_r   <= e_nxt;
    if (en_f) f_r   <= f_nxt;
    if (en_o) out_r <= out_nxt;
  end

  // clamp and seconds of day
  logic [4:0] hour_c;
  logic [5:0] minute_c, second_c;

  always_comb begin
    b_nxt.year = (a_r.utc_year > YEAR_MAX) ? YEAR_MAX : a_r.utc_year;
    if (a_r.utc_month < MONTH_JAN)      b_nxt.month = MONTH_JAN;
    else if (a_r.utc_month > MONTH_DEC) b_nxt.month = MONTH_DEC;
    else                                b_nxt.month = a_r.utc_month;
    b_nxt.mlen = days_in(b_nxt.year, b_nxt.month);
    if (a_r.utc_day == 5'd0)          b_nxt.day = 5'd1;
    else if (a_r.utc_day > b_nxt.mlen) b_nxt.day = b_nxt.mlen;
    else                              b_nxt.day = a_r.utc_day;
    hour_c   = (a_r.utc_hour > HOUR_MAX) ? HOUR_MAX : a_r.utc_hour;
    minute_c = (a_r.utc_minute > MINSEC_MAX) ? MINSEC_MAX : a_r.utc_minute;
    second_c = (a_r.utc_second > MINSEC_MAX) ? MINSEC_MAX : a_r.utc_second;
    b_nxt.secs = ({12'b0, hour_c} * HOUR_SECONDS)
               + ({11'b0, minute_c} * 17'(MINUTE_SECONDS))
               + {11'b0, second_c};
  end

  // offset and one-day roll
  logic [17:0] sum_e, sum_w;

  always_comb begin
    c_nxt.year  = b_r.year;
    c_nxt.month = b_r.month;
    c_nxt.day   = b_r.day;
    sum_e = {1'b0, b_r.secs} + {2'b0, zone_offset_r};
    sum_w = {1'b0, b_r.secs} + {1'b0, DAY_SECONDS} - {2'b0, zone_offset_r};
    if (zone_east_r) begin
      if (sum_e < {1'b0, DAY_SECONDS}) begin
        c_nxt.loc_secs = sum_e[16:0];
      end else begin
        c_nxt.loc_secs = 17'(sum_e - {1'b0, DAY_SECONDS});
        if (b_r.day < b_r.mlen) begin
          c_nxt.day = b_r.day + 5'd1;
        end else begin
          c_nxt.day = 5'd1;
          if (b_r.month < MONTH_DEC) begin
            c_nxt.month = b_r.month + 4'd1;
          end else begin
            c_nxt.month = MONTH_JAN;
            c_nxt.year  = (b_r.year == YEAR_MAX) ? 7'd0 : b_r.year + 7'd1;
          end
        end
      end
    end else begin
      if (b_r.secs >= {1'b0, zone_offset_r}) begin
        c_nxt.loc_secs = b_r.secs - {1'b0, zone_offset_r};
      end else begin
        c_nxt.loc_secs = sum_w[16:0];
        if (b_r.day > 5'd1) begin
          c_nxt.day = b_r.day - 5'd1;
        end else if (b_r.month > MONTH_JAN) begin
          c_nxt.month = b_r.month - 4'd1;
          c_nxt.day   = days_in(b_r.year, c_nxt.month);
        end else begin
          c_nxt.year  = (b_r.year == 7'd0) ? YEAR_MAX : b_r.year - 7'd1;
          c_nxt.month = MONTH_DEC;
          c_nxt.day   = 5'd31;
        end
      end
    end
  end

  // hour by reciprocal; Zeller sum (century terms fold to 0 for 20xx, 1 for 1999)
  logic [35:0] hour_prod;
  logic        early;
  logic [6:0]  zk;
  logic        cent;

  always_comb begin
    d_nxt.year     = c_r.year;
    d_nxt.month    = c_r.month;
    d_nxt.day      = c_r.day;
    d_nxt.loc_secs = c_r.loc_secs;
    hour_prod  = {19'b0, c_r.loc_secs} * {17'b0, HOUR_RECIP};
    d_nxt.hour = hour_prod[34:30];
    early = (c_r.month < MONTH_MAR);
    cent  = early && (c_r.year == 7'd0);
    if (cent)       zk = YEAR_MAX;
    else if (early) zk = c_r.year - 7'd1;
    else            zk = c_r.year;
    d_nxt.wsum = {3'b0, c_r.day} + {5'b0, zeller_term(c_r.month)} + {1'b0, zk}
               + {3'b0, zk[6:2]} + {7'b0, cent};
  end

  logic [2:0] zh;

  always_comb begin
    e_nxt.year     = d_r.year;
    e_nxt.month    = d_r.month;
    e_nxt.day      = d_r.day;
    e_nxt.loc_secs = d_r.loc_secs;
    e_nxt.hour     = d_r.hour;
    e_nxt.rem      = 12'(d_r.loc_secs - ({12'b0, d_r.hour} * HOUR_SECONDS));
    zh             = mod7(d_r.wsum);
    e_nxt.weekday  = (zh == 3'd0) ? 3'd6 : zh - 3'd1;
  end

  logic [24:0] min_prod;

  always_comb begin
    f_nxt.year     = e_r.year;
    f_nxt.month    = e_r.month;
    f_nxt.day      = e_r.day;
    f_nxt.loc_secs = e_r.loc_secs;
    f_nxt.hour     = e_r.hour;
    f_nxt.rem      = e_r.rem;
    f_nxt.weekday  = e_r.weekday;
    min_prod       = {13'b0, e_r.rem} * {12'b0, MINUTE_RECIP};
    f_nxt.minute   = min_prod[23:18];
  end

  logic [11:0] sec_full;
  logic [7:0]  month_bcd, day_bcd, hour_bcd, minute_bcd, second_bcd;

  always_comb begin
    sec_full   = f_r.rem - ({6'b0, f_r.minute} * MINUTE_SECONDS);
    month_bcd  = to_bcd({3'b0, f_r.month});
    day_bcd    = to_bcd({2'b0, f_r.day});
    hour_bcd   = to_bcd({2'b0, f_r.hour});
    minute_bcd = to_bcd({1'b0, f_r.minute});
    second_bcd = to_bcd({1'b0, sec_full[5:0]});
    out_nxt.local_year_bcd    = to_bcd(f_r.year);
    out_nxt.local_month_bcd   = month_bcd[4:0];
    out_nxt.local_day_bcd     = day_bcd[5:0];
    out_nxt.local_hour_bcd    = hour_bcd[5:0];
    out_nxt.local_minute_bcd  = minute_bcd[6:0];
    out_nxt.local_second_bcd  = second_bcd[6:0];
    out_nxt.local_weekday     = f_r.weekday;
    out_nxt.local_day_seconds = f_r.loc_secs;
  end

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while result side drains");

  a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.local_day_seconds < DAY_SECONDS))
    else $error("local seconds out of range");

  a_weekday: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.local_weekday != 3'd7))
    else $error("weekday out of range");

  a_bcd_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.local_second_bcd[3:0] <= 4'd9
                   && out_data.local_minute_bcd[3:0] <= 4'd9))
    else $error("bad BCD digit");

endmodule

`default_nettype wire
